@@ hw/rtl/frame_delta_rle_encoder_defines.svh @@
// Assertion macros for the bound checker in hw/rtl.
`ifndef FRAME_DELTA_RLE_ENCODER_DEFINES_SVH
`define FRAME_DELTA_RLE_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FDRE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FDRE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/fdre_pkg.sv @@
package fdre_pkg;

  localparam logic [3:0] RUN_MAX = 4'hF;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  typedef struct packed {
    logic        command;
    logic [15:0] pixel_word;
    logic        first_pixel;
    logic        last_pixel;
  } in_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       frame_end;
  } out_t;

  // up to two codes per pixel: a run boundary, then the end-of-frame flush
  typedef struct packed {
    logic       a_valid;
    logic [7:0] a_code;
    logic       b_valid;
    logic [7:0] b_code;
  } job_t;

endpackage

@@ hw/rtl/fdre_ram.sv @@
module fdre_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/fdre_front.sv @@
module fdre_front #(
  parameter int FRAME_PIXELS = 16384
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  fdre_pkg::in_t in_data,
  output logic          job_push,
  output fdre_pkg::job_t job,
  input  logic          job_full
);

  localparam int PW = $clog2(FRAME_PIXELS);
  localparam int FW = $clog2(FRAME_PIXELS + 1);

  logic          accept;
  logic [PW-1:0] addr;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          addr_fresh;

  logic          s2_valid_r, s2_valid_nxt;
  logic          s2_cmd_r;
  logic [3:0]    s2_q_r;
  logic          s2_first_r;
  logic          s2_last_r;
  logic [PW-1:0] s2_addr_r;
  logic          s2_zero_r;
  logic          s2_fwd_r;
  logic [3:0]    fwd_q_r;

  logic [3:0]    run_sym_r, run_sym_nxt;
  logic [3:0]    run_len_r, run_len_nxt;

  logic [3:0]    rdata;
  logic [3:0]    ref_q;
  logic [3:0]    sym;
  logic [3:0]    len0;
  logic          cont;
  logic [3:0]    len1;
  logic [3:0]    sym1;
  logic          s2_go;
  logic          s2_adv;

  assign accept = in_valid && !in_stall;
  assign addr   = in_data.first_pixel ? '0 : pos_r;
  // entries at or past the fill mark were never written and read as zero
  assign addr_fresh = (FW'(addr) == fill_r);

  always_comb begin
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    if (accept) begin
      if (in_data.last_pixel || addr == PW'(FRAME_PIXELS - 1)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = addr + 1'b1;
      end
      if (addr_fresh) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  fdre_ram #(
    .WIDTH(4),
    .DEPTH(FRAME_PIXELS)
  ) u_ref (
    .clk  (clk),
    .we   (s2_adv),
    .waddr(s2_addr_r),
    .wdata(s2_q_r),
    .re   (accept),
    .raddr(addr),
    .rdata(rdata)
  );

  always_comb begin
    if (s2_fwd_r) begin
      ref_q = fwd_q_r;
    end else if (s2_zero_r) begin
      ref_q = 4'h0;
    end else begin
      ref_q = rdata;
    end
    sym  = s2_cmd_r ? (s2_q_r - ref_q) : s2_q_r;
    len0 = s2_first_r ? 4'h0 : run_len_r;
    cont = (len0 != 4'h0) && (sym == run_sym_r) && (len0 != fdre_pkg::RUN_MAX);
    if (cont) begin
      sym1 = run_sym_r;
      len1 = len0 + 1'b1;
    end else begin
      sym1 = sym;
      len1 = 4'h1;
    end
    job.a_valid = !cont && (len0 != 4'h0);
    job.a_code  = {run_sym_r, len0};
    job.b_valid = s2_last_r;
    job.b_code  = {sym1, len1};
  end

  assign s2_go    = !(job.a_valid || job.b_valid) || !job_full;
  assign s2_adv   = s2_valid_r && s2_go;
  assign in_stall = s2_valid_r && !s2_go;
  assign job_push = s2_adv && (job.a_valid || job.b_valid);

  always_comb begin
    run_sym_nxt  = run_sym_r;
    run_len_nxt  = run_len_r;
    s2_valid_nxt = s2_valid_r;
    if (s2_adv) begin
      run_sym_nxt  = sym1;
      run_len_nxt  = s2_last_r ? 4'h0 : len1;
      s2_valid_nxt = 1'b0;
    end
    if (accept) begin
      s2_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      fill_r     <= '0;
      run_sym_r  <= 4'h0;
      run_len_r  <= 4'h0;
      s2_valid_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      fill_r     <= fill_nxt;
      run_sym_r  <= run_sym_nxt;
      run_len_r  <= run_len_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
    if (accept) begin
      s2_cmd_r   <= in_data.command;
      s2_q_r     <= in_data.pixel_word[15:12];
      s2_first_r <= in_data.first_pixel;
      s2_last_r  <= in_data.last_pixel;
      s2_addr_r  <= addr;
      s2_zero_r  <= addr_fresh;
      // read and write of one entry on the same edge: take the written value
      s2_fwd_r   <= s2_adv && (s2_addr_r == addr);
      fwd_q_r    <= s2_q_r;
    end
  end

endmodule

@@ hw/rtl/fdre_queue.sv @@
module fdre_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fdre_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output fdre_pkg::job_t head
);

  fdre_pkg::job_t                mem_r [fdre_pkg::QDEPTH];
  logic [fdre_pkg::QAW-1:0] wptr_r, wptr_nxt;
  logic [fdre_pkg::QAW-1:0] rptr_r, rptr_nxt;
  logic [fdre_pkg::QCW-1:0] count_r, count_nxt;

  assign full       = (count_r == fdre_pkg::QCW'(fdre_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/fdre_back.sv @@
module fdre_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  fdre_pkg::job_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output fdre_pkg::out_t out_data
);

  logic           out_valid_r, out_valid_nxt;
  fdre_pkg::out_t out_data_r, out_data_nxt;
  logic           a_done_r, a_done_nxt;
  logic           out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    a_done_nxt    = a_done_r;
    pop           = 1'b0;
    if (head_valid && out_free) begin
      out_valid_nxt = 1'b1;
      if (head.a_valid && !a_done_r) begin
        out_data_nxt = '{code_byte: head.a_code, frame_end: 1'b0};
        if (head.b_valid) begin
          a_done_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        out_data_nxt = '{code_byte: head.b_code, frame_end: 1'b1};
        a_done_nxt   = 1'b0;
        pop          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      a_done_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      a_done_r    <= a_done_nxt;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

@@ hw/rtl/frame_delta_rle_encoder.sv @@
// Frame delta run-length encoder.
// Input: one pixel per transfer on in_valid/in_stall/in_data. Bits 15..12 of
// pixel_word are kept; command 0 codes that value, command 1 codes its
// difference mod 16 to the same position of the previous frame.
// Output: code bytes on out_valid/out_stall/out_data, symbol in the high
// nibble, run length 1..15 in the low nibble; frame_end marks the flush
// caused by last_pixel. A pixel yields zero, one or two code bytes.
// Throughput: one pixel per clock while the queue has room, set by the
// single-entry read/write of the reference memory (read at accept, written
// as the pixel leaves the coder stage, with bypass). Code bytes pass the
// coder stage, queue and output register; a pixel's second byte follows.
// A 4-entry queue sits between the coder and the output register, so the
// output may stall while pixels keep flowing until it fills; then in_stall
// rises. The output register holds its byte while out_stall is high.
// Reset: position, run and queue clear; the reference memory is not swept,
// a fill mark makes never-written entries read as zero, so the block takes
// pixels in the first cycle after reset.
module frame_delta_rle_encoder #(
  parameter int FRAME_PIXELS = 16384
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  fdre_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output fdre_pkg::out_t out_data
);

  logic           job_push;
  fdre_pkg::job_t job;
  logic           job_full;
  logic           head_valid;
  fdre_pkg::job_t head;
  logic           pop;

  fdre_front #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .job_push(job_push),
    .job     (job),
    .job_full(job_full)
  );

  fdre_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job),
    .full      (job_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  fdre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/fdre_checker.sv @@
`include "frame_delta_rle_encoder_defines.svh"

module fdre_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input fdre_pkg::out_t out_data
);

  `FDRE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "output changed while stalled")
  `FDRE_ASSERT_IMP(a_run_len, out_valid, out_data.code_byte[3:0] != 4'h0, "zero run length")
  `FDRE_ASSERT_IMP(a_reset_idle, $rose(rst_n), !in_stall && !out_valid, "not idle after reset")
  `FDRE_ASSERT_IMP(a_stall_cause, in_stall, out_valid, "input stalled with output empty")

endmodule

bind frame_delta_rle_encoder fdre_checker u_chk (.*);

@@ verif/fdre_checker.sv @@
`timescale 1ns / 100ps
module fdre_scoreboard #(
  parameter int FRAME_PIXELS = 16384
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  fdre_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  fdre_pkg::out_t out_data,
  output int             fail_count,
  output int             pending,
  output int             code_count
);

  logic [3:0]     ref_store [FRAME_PIXELS];
  int             pixel_pos;
  logic [3:0]     run_sym;
  logic [3:0]     run_len;
  fdre_pkg::out_t code_q [$];
  int             errors;
  int             codes;

  task automatic queue_code(input logic [3:0] sym, input logic [3:0] len, input logic fe);
    fdre_pkg::out_t c;
    c.code_byte = {sym, len};
    c.frame_end = fe;
    code_q.push_back(c);
  endtask

  always @(posedge clk) begin : monitor
    logic [3:0]     q;
    logic [3:0]     sym;
    fdre_pkg::out_t want;
    if (!rst_n) begin
      for (int k = 0; k < FRAME_PIXELS; k++) ref_store[k] = '0;
      pixel_pos = 0;
      run_sym   = '0;
      run_len   = '0;
      code_q.delete();
      errors    = 0;
      codes     = 0;
    end else begin
      if (in_valid && !in_stall) begin
        q = in_data.pixel_word[15:12];
        if (in_data.first_pixel) begin
          pixel_pos = 0;
          run_len   = '0;
        end
        sym = in_data.command ? q - ref_store[pixel_pos] : q;
        ref_store[pixel_pos] = q;
        pixel_pos = (pixel_pos == FRAME_PIXELS - 1) ? 0 : pixel_pos + 1;
        if (run_len != '0 && sym == run_sym && run_len != fdre_pkg::RUN_MAX) begin
          run_len = run_len + 4'd1;
        end else begin
          if (run_len != '0) queue_code(run_sym, run_len, 1'b0);
          run_sym = sym;
          run_len = 4'd1;
        end
        if (in_data.last_pixel) begin
          queue_code(run_sym, run_len, 1'b1);
          run_len   = '0;
          pixel_pos = 0;
        end
      end
      if (out_valid && !out_stall) begin
        codes++;
        if (code_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected code transfer %02h frame_end %0b", $realtime,
                     out_data.code_byte, out_data.frame_end);
        end else begin
          want = code_q.pop_front();
          if (want.code_byte !== out_data.code_byte || want.frame_end !== out_data.frame_end)
          begin
            errors++;
            if (errors <= 10)
              $display("%0t: code mismatch: expected %02h/%0b, got %02h/%0b", $realtime,
                       want.code_byte, want.frame_end, out_data.code_byte,
                       out_data.frame_end);
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= code_q.size();
    code_count <= codes;
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
module tb;

  localparam int FRAME_PIXELS = 16384;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_PIXELS = 2000;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  fdre_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  fdre_pkg::out_t out_data;

  int fail_count;
  int pending;
  int code_count;

  int   sent_pixels;
  int   frame_count;
  int   idle_cycles;
  bit   calm;
  bit   hold_req;
  bit   hold_done;
  bit   paused;
  logic [3:0] scene [256];

  frame_delta_rle_encoder #(.FRAME_PIXELS(FRAME_PIXELS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  fdre_scoreboard #(.FRAME_PIXELS(FRAME_PIXELS)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending),
    .code_count(code_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one pixel transfer, with an optional idle gap in front
  task automatic send_pixel(input logic cmd, input logic [15:0] pix, input logic fst,
                            input logic lst);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = calm ? 0 : (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(4, 25);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, pixel_word: pix, first_pixel: fst, last_pixel: lst};
    do @(posedge clk); while (in_stall);
    sent_pixels++;
  endtask

  task automatic send_frame(input int len, input logic delta, input bit noisy,
                            input int delta_from);
    int         r;
    logic [3:0] nib;
    logic       cmd;
    logic       fst;
    logic       lst;
    nib = 4'($urandom);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r >= 85) nib = 4'($urandom);
      else if (r >= 60) nib = scene[i & 255];
      scene[i & 255] = nib;
      cmd = (i >= delta_from) ? 1'b1 : noisy ? 1'($urandom) : delta;
      fst = (i == 0);
      lst = (i == len - 1);
      if (noisy && $urandom_range(0, 9) == 0) fst = ~fst;
      if (noisy && $urandom_range(0, 9) == 0) lst = ~lst;
      send_pixel(cmd, {nib, 12'($urandom)}, fst, lst);
    end
    frame_count++;
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin : receiver
    int r;
    int len;
    out_stall = 1'b0;
    hold_done = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        out_stall <= (r >= 70);
        len = (r < 7) ? $urandom_range(40, 80) : (r < 70) ? $urandom_range(1, 12) :
              (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        repeat (len) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: no transfer for %0d cycles, %0d codes outstanding", idle_cycles,
                 pending);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int r;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    hold_req    = 1'b0;
    paused      = 1'b0;
    calm        = 1'b0;
    sent_pixels = 0;
    frame_count = 0;
    for (int i = 0; i < 256; i++) scene[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // single-pixel frames, keyframe then delta against it
    send_pixel(1'b0, 16'hFFFF, 1'b1, 1'b1);
    send_pixel(1'b1, 16'h0000, 1'b1, 1'b1);
    // sixteen equal pixels: run split at 15 meets the flush on the last one
    for (int i = 0; i < 16; i++)
      send_pixel(1'b0, 16'hA000 | 16'(i * 16'h0111), i == 0, i == 15);
    // open run dropped by a new first pixel
    send_pixel(1'b0, 16'h5FFF, 1'b1, 1'b0);
    send_pixel(1'b0, 16'h6000, 1'b1, 1'b1);
    // symbol change and flush on one pixel, delta mode
    send_pixel(1'b1, 16'h1000, 1'b1, 1'b0);
    send_pixel(1'b1, 16'h2ABC, 1'b0, 1'b1);
    frame_count += 6;

    while (sent_pixels < RANDOM_PIXELS + 22) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) calm = ~calm;
      send_frame((r < 85) ? $urandom_range(1, 40) : (r < 97) ? $urandom_range(41, 200) :
                 $urandom_range(1, 3), 1'($urandom), $urandom_range(0, 99) < 15, 1 << 30);
      if (!hold_req && sent_pixels > 800) hold_req = 1'b1;
      if (!paused && sent_pixels > 1400) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
    end

    calm = 1'b0;
    send_frame(8, 1'b1, 1'b0, 1 << 30);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);

    $display("tb: %0d pixels in %0d frames, %0d code bytes compared", sent_pixels,
             frame_count, code_count);
    $display("tb: covered run splits, dropped runs, mixed modes and output back-pressure");
    if (pending != 0) $display("tb: %0d expected code bytes never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/fdre_pkg.sv
hw/rtl/fdre_ram.sv
hw/rtl/fdre_front.sv
hw/rtl/fdre_queue.sv
hw/rtl/fdre_back.sv
hw/rtl/frame_delta_rle_encoder.sv
hw/rtl/fdre_checker.sv
verif/fdre_checker.sv
verif/tb.sv
